>>> design/dpq_pkg.sv
// Package for the descending priority queue.
// Holds the command and status codes, the stored entry and the result record.
// No dependencies.
`default_nettype none

package dpq_pkg;

    localparam int OCC_W  = 5;
    localparam int DATA_W = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STS_INSERTED = 2'd0,
        STS_REMOVED  = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_REM,
        SQ_INS_RD,
        SQ_INS_CMP
    } seq_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] elem;
    } entry_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic signed [DATA_W-1:0] priority_val;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

`default_nettype wire

>>> design/dpq_if.sv
// Channel interfaces for the descending priority queue.
// Request carries a command and an entry, response carries the outcome.
// No dependencies.
`default_nettype none

interface dpq_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] element;
    logic signed [31:0] priority_req;

    modport source (output valid, command, element, priority_req, input ready);
    modport sink   (input valid, command, element, priority_req, output ready);
endinterface

interface dpq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_element;
    logic signed [31:0] removed_priority;
    logic [4:0]         occupancy;

    modport source (output valid, status, removed_element, removed_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, removed_element, removed_priority, occupancy,
                    output ready);
endinterface

`default_nettype wire

>>> design/descending_priority_queue.sv
// Descending priority queue: a bounded sorted store of DEPTH entries.
//
// Channels: req carries one item (command, element, priority_req); rsp returns
// one item per request (status, removed_element, removed_priority, occupancy).
// Both use valid/ready; an item moves on a clock edge with both high.
//
// Entries sit in a ring in one memory, head first. A remove reads the head
// entry and advances the head pointer. An insert scans from the tail toward
// the head with one shared compare and ring address adder: each entry whose
// priority is not above the new one moves one slot back; each moved entry is
// first read from memory, then compared and written.
//
// One item is in work at a time: req.ready stays low until the response has
// been taken, so a stalled receiver holds the result and the queue.
//
// Reset empties the queue at once; memory contents are not cleared.
// Depends on dpq_pkg, dpq_if and dpq_seq.
`default_nettype none

module descending_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dpq_req_if.sink    req,
    dpq_rsp_if.source  rsp
);
    import dpq_pkg::*;

    logic    busy_reg, busy_next;
    logic    start_reg, start_next;
    logic    out_valid_reg, out_valid_next;
    cmd_t    cmd_reg;
    entry_t  item_reg;
    result_t rsp_reg;

    logic    req_fire;
    logic    rsp_fire;
    logic    seq_done;
    result_t seq_result;

    dpq_seq #(.DEPTH(DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .cmd       (cmd_reg),
        .new_entry (item_reg),
        .done      (seq_done),
        .result    (seq_result)
    );

    assign req.ready = !busy_reg && !out_valid_reg;
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    always_comb
    begin
        start_next     = req_fire;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (req_fire)
        begin
            busy_next = 1'b1;
        end
        if (seq_done)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the request fields for the whole operation
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg       <= cmd_t'(req.command);
            item_reg.elem <= req.element;
            item_reg.prio <= req.priority_req;
        end
        if (seq_done)
        begin
            rsp_reg <= seq_result;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = rsp_reg.status;
    assign rsp.removed_element  = rsp_reg.element;
    assign rsp.removed_priority = rsp_reg.priority_val;
    assign rsp.occupancy        = rsp_reg.occupancy;

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> busy_reg && !out_valid_reg)
        else $error("sequencer finished with no item in work");

    a_done_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |=> rsp.valid && !busy_reg)
        else $error("finished item not presented");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && out_valid_reg))
        else $error("new item started while a result waits");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp_reg.status == STS_EMPTY || rsp_reg.status == STS_FULL)
        |-> rsp.removed_element == '0 && rsp.removed_priority == '0)
        else $error("data fields not zero on a rejected item");

endmodule

`default_nettype wire

>>> design/dpq_store.sv
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on dpq_pkg for the entry type.
`default_nettype none

module dpq_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output dpq_pkg::entry_t                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire dpq_pkg::entry_t              wr_data
);
    import dpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/dpq_wrap_add.sv
// Ring address unit: adds a logical position to the head pointer and wraps at DEPTH.
// Shared by the insert scan and the head advance of the sequencer. No dependencies.
`default_nettype none

module dpq_wrap_add #(
    parameter int DEPTH = 16
) (
    input  wire logic [$clog2(DEPTH)-1:0] base,
    input  wire logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0]      sum
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic [AW:0] raw;

    assign raw = {1'b0, base} + {1'b0, offset};
    assign sum = (raw >= DEPTH_W) ? AW'(raw - DEPTH_W) : raw[AW-1:0];

endmodule

`default_nettype wire

>>> design/dpq_seq.sv
// Sequencer of the priority queue: keeps head, count and scan position,
// walks inserts from the tail toward the head one entry at a time.
// Depends on dpq_pkg, dpq_store and dpq_wrap_add.
`default_nettype none

module dpq_seq #(
    parameter int DEPTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire dpq_pkg::cmd_t    cmd,
    input  wire dpq_pkg::entry_t  new_entry,
    output logic                  done,
    output dpq_pkg::result_t      result
);
    import dpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] pos_reg, pos_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;
    logic [AW-1:0] offset;
    logic [AW-1:0] addr_sum;
    logic          shift_down;

    dpq_store #(.DEPTH(DEPTH)) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dpq_wrap_add #(.DEPTH(DEPTH)) u_addr (
        .base   (head_reg),
        .offset (offset),
        .sum    (addr_sum)
    );

    // the new entry passes every entry whose priority is not above its own
    assign shift_down = (rd_data.prio <= new_entry.prio);

    always_comb
    begin
        case (state_reg)
            SQ_INS_RD:  offset = pos_reg - AW'(1);
            SQ_INS_CMP: offset = pos_reg;
            SQ_REM:     offset = AW'(1);
            default:    offset = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_REMOVE)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = SQ_REM;
                        end
                    end
                    else if (count_reg != FULL_CNT)
                    begin
                        state_next = SQ_INS_RD;
                    end
                end
            end
            SQ_REM:
            begin
                state_next = SQ_IDLE;
            end
            SQ_INS_RD:
            begin
                state_next = (pos_reg == '0) ? SQ_IDLE : SQ_INS_CMP;
            end
            SQ_INS_CMP:
            begin
                state_next = shift_down ? SQ_INS_RD : SQ_IDLE;
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // outputs: memory controls and result
    always_comb
    begin
        done    = 1'b0;
        result  = '{status: STS_INSERTED, element: '0, priority_val: '0,
                    occupancy: OCC_W'(count_reg)};
        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = addr_sum;
        wr_data = rd_data;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            done          = 1'b1;
                            result.status = STS_EMPTY;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        done          = 1'b1;
                        result.status = STS_FULL;
                    end
                end
            end
            SQ_REM:
            begin
                done                = 1'b1;
                result.status       = STS_REMOVED;
                result.element      = rd_data.elem;
                result.priority_val = rd_data.prio;
                result.occupancy    = OCC_W'(count_reg - CW'(1));
            end
            SQ_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = head_reg;
                    wr_data          = new_entry;
                    done             = 1'b1;
                    result.occupancy = OCC_W'(count_reg + CW'(1));
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = addr_sum;
                end
            end
            SQ_INS_CMP:
            begin
                wr_en = 1'b1;
                if (!shift_down)
                begin
                    wr_data          = new_entry;
                    done             = 1'b1;
                    result.occupancy = OCC_W'(count_reg + CW'(1));
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // head, count and scan position
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        pos_next   = pos_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start && cmd == CMD_INSERT)
                begin
                    pos_next = count_reg[AW-1:0];
                end
            end
            SQ_REM:
            begin
                count_next = count_reg - CW'(1);
                head_next  = addr_sum;
            end
            SQ_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            SQ_INS_CMP:
            begin
                if (shift_down)
                begin
                    pos_next = pos_reg - AW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the descending priority queue: directed corners, then random traffic.
// Predicts each response from a sorted shadow store and checks it in order.
// Depends on dpq_pkg, dpq_if and the descending_priority_queue RTL.
`timescale 1ns / 1ps

module tb_top;
    import dpq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_REPORTS    = 20;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    dpq_req_if req ();
    dpq_rsp_if rsp ();

    descending_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the sorted store, head at index 0
    logic signed [31:0] held_elem [DEPTH];
    logic signed [31:0] held_prio [DEPTH];
    int                 held_count;

    result_t pending_outcomes[$];
    int      error_count;
    int      idle_pct;
    int      stall_pct;
    int      quiet_cycles;

    always #4 clk = ~clk;

    function automatic result_t store_apply(cmd_t cmd, logic signed [31:0] elem,
                                            logic signed [31:0] prio);
        result_t outcome;
        int      pos;
        outcome.element      = '0;
        outcome.priority_val = '0;
        if (cmd == CMD_INSERT) begin
            if (held_count >= DEPTH) begin
                outcome.status = STS_FULL;
            end
            else begin
                pos = 0;
                // skip past every entry that outranks the new one
                while (pos < held_count && prio < held_prio[pos])
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_elem[i] = held_elem[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_elem[pos] = elem;
                held_prio[pos] = prio;
                held_count++;
                outcome.status = STS_INSERTED;
            end
        end
        else begin
            if (held_count == 0) begin
                outcome.status = STS_EMPTY;
            end
            else begin
                outcome.element      = held_elem[0];
                outcome.priority_val = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_elem[i-1] = held_elem[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
                outcome.status = STS_REMOVED;
            end
        end
        outcome.occupancy = held_count[OCC_W-1:0];
        return outcome;
    endfunction

    // Present one item, hold it until taken, then record its predicted outcome
    task automatic send_request(cmd_t cmd, logic signed [31:0] elem,
                                logic signed [31:0] prio);
        while ($urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.element      <= elem;
        req.priority_req <= prio;
        do
            @(posedge clk);
        while (!req.ready);
        pending_outcomes.push_back(store_apply(cmd, elem, prio));
    endtask

    task automatic test_directed_corners();
        send_request(CMD_REMOVE, $urandom, $urandom);
        // equal priorities: newest must come out first
        send_request(CMD_INSERT, 32'sd1, 32'sd0);
        send_request(CMD_INSERT, 32'sd2, 32'sd0);
        send_request(CMD_INSERT, 32'sd3, 32'sd0);
        send_request(CMD_INSERT, 32'sh7fff_ffff, PRIO_MAX);
        send_request(CMD_INSERT, 32'sh8000_0000, PRIO_MIN);
        send_request(CMD_INSERT, -32'sd1, -32'sd1);
        send_request(CMD_INSERT, 32'sd0, 32'sd1);
        send_request(CMD_INSERT, 32'sd5, PRIO_MAX);
        send_request(CMD_INSERT, 32'sd6, PRIO_MIN);
        repeat (DEPTH - 9)
            send_request(CMD_INSERT, $urandom, $urandom);
        // store is full now: both inserts must be dropped
        send_request(CMD_INSERT, $urandom, PRIO_MAX);
        send_request(CMD_INSERT, $urandom, PRIO_MIN);
        repeat (5)
            send_request(CMD_REMOVE, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(int n_items);
        int                 sent;
        int                 run_len;
        int                 insert_pct;
        int                 prio_mode;
        logic signed [31:0] base_prio;
        logic signed [31:0] prio;
        cmd_t               cmd;
        sent = 0;
        while (sent < n_items) begin
            run_len   = $urandom_range(40, 4);
            prio_mode = $urandom_range(3);
            base_prio = $urandom;
            case ($urandom_range(4))
                0: insert_pct = 90;
                1: insert_pct = 70;
                2: insert_pct = 50;
                3: insert_pct = 30;
                default: insert_pct = 10;
            endcase
            for (int i = 0; i < run_len; i++) begin
                cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                case (prio_mode)
                    0: prio = $urandom;
                    // narrow band: lots of ties
                    1: prio = base_prio + $signed($urandom_range(3));
                    2: prio = $signed($urandom_range(6)) - 32'sd3;
                    default:
                        case ($urandom_range(4))
                            0: prio = PRIO_MAX;
                            1: prio = PRIO_MIN;
                            2: prio = 32'sd0;
                            3: prio = -32'sd1;
                            default: prio = 32'sd1;
                        endcase
                endcase
                send_request(cmd, $urandom, prio);
            end
            sent += run_len;
        end
    endtask

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if (rsp.valid && rsp.ready) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected item: status %0d elem %0d prio %0d occ %0d",
                             $time, rsp.status, rsp.removed_element,
                             rsp.removed_priority, rsp.occupancy);
            end
            else begin
                if (rsp.status !== pending_outcomes[0].status
                        || rsp.removed_element !== pending_outcomes[0].element
                        || rsp.removed_priority !== pending_outcomes[0].priority_val
                        || rsp.occupancy !== pending_outcomes[0].occupancy) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected status %0d elem %0d prio %0d ",
                                  "occ %0d, actual status %0d elem %0d prio %0d occ %0d"},
                                 $time, pending_outcomes[0].status,
                                 pending_outcomes[0].element,
                                 pending_outcomes[0].priority_val,
                                 pending_outcomes[0].occupancy, rsp.status,
                                 rsp.removed_element, rsp.removed_priority, rsp.occupancy);
                end
                void'(pending_outcomes.pop_front());
            end
        end
    end

    // Abort if neither channel moves an item for too long
    always @(posedge clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.command      = CMD_INSERT;
        req.element      = '0;
        req.priority_req = '0;
        rsp.ready        = 1'b0;
        held_count       = 0;
        error_count      = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        quiet_cycles     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_traffic(470);
        idle_pct = 54;
        test_random_traffic(470);
        idle_pct  = 0;
        stall_pct = 54;
        test_random_traffic(470);
        idle_pct  = 16;
        stall_pct = 16;
        test_random_traffic(470);

        req.valid <= 1'b0;
        stall_pct = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
